FILE: design/linear_probe_hash_table_top_macros.svh
// Assertion macros shared by the checker of the linear probe hash table.
`ifndef LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_TOP_MACROS_SVH
// Property holds on every clock edge out of reset.
`define LPHT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lpht check failed");
// Property is also checked while reset is asserted.
`define LPHT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("lpht check failed");
`endif

FILE: design/lpht_pkg.sv
// Package: constants, types and helpers of the linear probe hash table.
package lpht_pkg;
    localparam int MAX_SLOTS_DEF = 1024;
    localparam int MIN_SLOTS_DEF = 8;
    localparam int KEY_W   = 64;
    localparam int HASH_W  = 32;
    localparam int VAL_W   = 64;
    localparam int CNT_W   = 11;
    localparam int CFG_W   = 4;
    localparam logic [CFG_W-1:0] RESET_CAP_LOG2 = 4'd3;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_PUT    = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // One table entry as stored in memory; used marks a live slot.
    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        logic [VAL_W-1:0]  value;
    } t_entry;

    // Request word.
    typedef struct packed {
        logic              mode;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] key_hash;
        logic [VAL_W-1:0]  value;
    } t_req;

    // Result word.
    typedef struct packed {
        logic              found;
        logic [VAL_W-1:0]  result_value;
        logic              status;
        logic [CNT_W-1:0]  entry_total;
    } t_rsp;
endpackage

FILE: design/lpht_if.sv
// Valid/ready channel interface carrying one word of type T.
interface lpht_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/lpht_mem.sv
// Slot memory: used bits, entry store and two banks for rehash.
module lpht_mem
    import lpht_pkg::*;
#(
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_bank_rd,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output t_entry            o_rd_entry,
    input  logic              i_wr_en,
    input  logic              i_bank_wr,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_entry            i_wr_entry
);
    localparam int DEPTH = 1 << ADDR_W;
    t_entry r_bank0 [DEPTH];
    t_entry r_bank1 [DEPTH];
    t_entry r_rd0, r_rd1;
    logic   r_sel;

    // Bank 0 port
    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_bank_wr) begin
            r_bank0[i_wr_addr] <= i_wr_entry;
        end
        r_rd0 <= r_bank0[i_rd_addr];
    end

    // Bank 1 port
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_bank_wr) begin
            r_bank1[i_wr_addr] <= i_wr_entry;
        end
        r_rd1 <= r_bank1[i_rd_addr];
        r_sel <= i_bank_rd;
    end

    assign o_rd_entry = r_sel ? r_rd1 : r_rd0;
endmodule

FILE: design/linear_probe_hash_table_top.sv
// Linear probing key/value table: each request word is a lookup or a put and gives one result
// word (found, value on a lookup hit, status, entry count). Slots live in a two-bank memory with
// registered reads; each entry holds a used bit, key, hash and value. A word is taken only when
// the sequencer is idle; each probed slot is read and then checked, and the finished result goes
// to the output register. A put that reaches the 3/4 load limit first grows the table: the new
// bank is cleared one slot per cycle over the doubled size, then each old slot is read and, if used,
// reinserted into the new bank by its stored hash, and the probe of the put starts over in the
// grown table. A register write is taken only when idle, sets the size and clears the current
// bank; after reset the same clear runs over the 8 slots of the reset size. The result sits in an
// output register, so the next word can be taken while it waits; a finished word then holds until
// that register is free.
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF,
    parameter int MIN_SLOTS = MIN_SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lpht_if.sink   cfg,
    lpht_if.sink   req,
    lpht_if.source rsp
);
    localparam int AW = $clog2(MAX_SLOTS);
    localparam int LO = $clog2(MIN_SLOTS);
    localparam int HI = $clog2(MAX_SLOTS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_CLR   = 10'b0000000010,
        S_PRD   = 10'b0000000100,
        S_PCHK  = 10'b0000001000,
        S_GCLR  = 10'b0000010000,
        S_GRD   = 10'b0000100000,
        S_GCHK  = 10'b0001000000,
        S_GPRD  = 10'b0010000000,
        S_GPCHK = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic r_bank, n_bank;
    logic [CFG_W-1:0] r_cap_log2, n_cap_log2;
    logic [CNT_W-1:0] r_count, n_count;
    t_req  r_req, n_req;
    t_rsp  r_res, n_res;
    t_rsp  r_rsp, n_rsp;
    logic  r_rsp_v, n_rsp_v;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_gi, n_gi;
    logic [AW:0]   r_n, n_n;
    logic          r_grown, n_grown;
    t_entry        r_gent, n_gent;

    t_entry rd_ent;
    logic   rd_bank;
    logic [AW-1:0] rd_addr;
    logic   wr_en, wr_bank;
    logic [AW-1:0] wr_addr;
    t_entry wr_ent;

    lpht_mem #(.ADDR_W(AW)) u_mem (
        .i_clk(i_clk), .i_bank_rd(rd_bank), .i_rd_addr(rd_addr), .o_rd_entry(rd_ent),
        .i_wr_en(wr_en), .i_bank_wr(wr_bank), .i_wr_addr(wr_addr), .i_wr_entry(wr_ent)
    );

    // capacity derived values
    logic [AW:0]   cap, ncap;
    logic [AW-1:0] mask, nmask;
    assign cap   = (AW+1)'(1) << r_cap_log2;
    assign ncap  = cap << 1;
    assign mask  = AW'(cap - 1'b1);
    assign nmask = AW'(ncap - 1'b1);

    // probe and pass conditions
    logic hit, grow_need, gi_last, gi_nlast, probe_last, gprobe_last, gp_place;
    t_entry new_ent;
    assign hit         = rd_ent.used && (rd_ent.key == r_req.key);
    assign grow_need   = ((CNT_W+3)'(r_count) + 1'b1) * 3'd4 >= (CNT_W+3)'(cap) * 2'd3;
    assign gi_last     = ({1'b0, r_gi} + (AW+1)'(1)) == cap;
    assign gi_nlast    = ({1'b0, r_gi} + (AW+1)'(1)) == ncap;
    assign probe_last  = (r_n + (AW+1)'(1)) == cap;
    assign gprobe_last = (r_n + (AW+1)'(1)) == ncap;
    assign gp_place    = !rd_ent.used || (rd_ent.key == r_gent.key);
    assign new_ent     = '{used: 1'b1, key: r_req.key, hash: r_req.key_hash,
                           value: r_req.value};

    logic req_fire, cfg_fire;
    assign cfg.ready = (r_state == S_IDLE);
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign req.ready = (r_state == S_IDLE) && !cfg.valid;
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = r_rsp_v;
    assign rsp.data  = r_rsp;

    // memory read and write selection
    always_comb begin
        rd_bank = r_bank;
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_bank = r_bank;
        wr_addr = r_idx;
        wr_ent  = new_ent;
        if (r_state == S_CLR) begin
            wr_en   = 1'b1;
            wr_addr = r_gi;
            wr_ent  = '0;
        end else if (r_state == S_GCLR) begin
            wr_en   = 1'b1;
            wr_bank = !r_bank;
            wr_addr = r_gi;
            wr_ent  = '0;
        end else if (r_state == S_GRD) begin
            rd_addr = r_gi;
        end else if (r_state == S_GPRD) begin
            rd_bank = !r_bank;
        end else if (r_state == S_GPCHK && gp_place) begin
            wr_en   = 1'b1;
            wr_bank = !r_bank;
            wr_ent  = r_gent;
        end else if (r_state == S_PCHK && r_req.mode == MODE_PUT) begin
            if (hit) begin
                wr_en  = 1'b1;
                wr_ent = '{used: 1'b1, key: rd_ent.key, hash: rd_ent.hash,
                           value: r_req.value};
            end else if (!rd_ent.used && (!grow_need || r_grown)) begin
                wr_en = 1'b1;
            end
        end
    end

    // main sequencer, next values
    always_comb begin
        n_state    = r_state;
        n_bank     = r_bank;
        n_cap_log2 = r_cap_log2;
        n_count    = r_count;
        n_req      = r_req;
        n_res      = r_res;
        n_rsp      = r_rsp;
        n_rsp_v    = r_rsp_v;
        n_idx      = r_idx;
        n_gi       = r_gi;
        n_n        = r_n;
        n_grown    = r_grown;
        n_gent     = r_gent;
        if (rsp.ready) n_rsp_v = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (cfg_fire) begin
                    if (cfg.data < CFG_W'(LO)) n_cap_log2 = CFG_W'(LO);
                    else if (cfg.data > CFG_W'(HI)) n_cap_log2 = CFG_W'(HI);
                    else n_cap_log2 = cfg.data;
                    n_count = '0;
                    n_gi    = '0;
                    n_state = S_CLR;
                end else if (req_fire) begin
                    n_req   = req.data;
                    n_idx   = req.data.key_hash[AW-1:0] & mask;
                    n_n     = '0;
                    n_grown = 1'b0;
                    n_state = S_PRD;
                end
            end
            // empty the current bank, one slot per cycle
            S_CLR: begin
                if (gi_last) n_state = S_IDLE;
                else n_gi = r_gi + 1'b1;
            end
            S_PRD: n_state = S_PCHK;
            S_PCHK: begin
                n_res.found        = 1'b0;
                n_res.result_value = '0;
                n_res.status       = STATUS_OK;
                n_res.entry_total  = r_count;
                if (hit) begin
                    n_res.found = 1'b1;
                    if (r_req.mode == MODE_LOOKUP) n_res.result_value = rd_ent.value;
                    n_state = S_OUT;
                end else if (!rd_ent.used) begin
                    if (r_req.mode == MODE_LOOKUP) begin
                        n_state = S_OUT;
                    end else if (grow_need && !r_grown) begin
                        if (cap < (AW+1)'(MAX_SLOTS)) begin
                            n_gi    = '0;
                            n_state = S_GCLR;
                        end else begin
                            n_res.status = STATUS_FULL;
                            n_state      = S_OUT;
                        end
                    end else begin
                        n_count           = r_count + 1'b1;
                        n_res.entry_total = r_count + 1'b1;
                        n_state           = S_OUT;
                    end
                end else if (probe_last) begin
                    if (r_req.mode == MODE_PUT) n_res.status = STATUS_FULL;
                    n_state = S_OUT;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_idx   = (r_idx + 1'b1) & mask;
                    n_state = S_PRD;
                end
            end
            // empty the new bank over the doubled size
            S_GCLR: begin
                if (gi_nlast) begin
                    n_gi    = '0;
                    n_state = S_GRD;
                end else begin
                    n_gi = r_gi + 1'b1;
                end
            end
            S_GRD: n_state = S_GCHK;
            S_GCHK: begin
                if (rd_ent.used) begin
                    n_gent  = rd_ent;
                    n_idx   = rd_ent.hash[AW-1:0] & nmask;
                    n_n     = '0;
                    n_state = S_GPRD;
                end else if (gi_last) begin
                    n_bank     = !r_bank;
                    n_cap_log2 = r_cap_log2 + 1'b1;
                    n_grown    = 1'b1;
                    n_idx      = r_req.key_hash[AW-1:0] & nmask;
                    n_n        = '0;
                    n_state    = S_PRD;
                end else begin
                    n_gi    = r_gi + 1'b1;
                    n_state = S_GRD;
                end
            end
            S_GPRD: n_state = S_GPCHK;
            S_GPCHK: begin
                if (gp_place || gprobe_last) begin
                    if (gi_last) begin
                        n_bank     = !r_bank;
                        n_cap_log2 = r_cap_log2 + 1'b1;
                        n_grown    = 1'b1;
                        n_idx      = r_req.key_hash[AW-1:0] & nmask;
                        n_n        = '0;
                        n_state    = S_PRD;
                    end else begin
                        n_gi    = r_gi + 1'b1;
                        n_state = S_GRD;
                    end
                end else begin
                    n_n     = r_n + 1'b1;
                    n_idx   = (r_idx + 1'b1) & nmask;
                    n_state = S_GPRD;
                end
            end
            // hand the result to the output register once it is free
            S_OUT: begin
                if (!r_rsp_v || rsp.ready) begin
                    n_rsp   = r_res;
                    n_rsp_v = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_bank     <= 1'b0;
            r_cap_log2 <= RESET_CAP_LOG2;
            r_count    <= '0;
            r_rsp_v    <= 1'b0;
            r_gi       <= '0;
        end else begin
            r_state    <= n_state;
            r_bank     <= n_bank;
            r_cap_log2 <= n_cap_log2;
            r_count    <= n_count;
            r_rsp_v    <= n_rsp_v;
            r_gi       <= n_gi;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_res   <= n_res;
        r_rsp   <= n_rsp;
        r_idx   <= n_idx;
        r_n     <= n_n;
        r_grown <= n_grown;
        r_gent  <= n_gent;
    end
endmodule

FILE: design/lpht_checker.sv
// Port-level checker for the linear probe hash table, bound to the top.
`include "linear_probe_hash_table_top_macros.svh"
module lpht_checker
    import lpht_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input t_rsp rsp_data
);
    `LPHT_ASSERT(a_rsp_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    `LPHT_ASSERT(a_lookup_zero, i_clk, i_rst_n, rsp_valid && !rsp_data.found |-> rsp_data.result_value == '0)
    `LPHT_ASSERT(a_total_max, i_clk, i_rst_n, rsp_valid |-> rsp_data.entry_total <= CNT_W'(MAX_SLOTS_DEF))
    `LPHT_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !rsp_valid)
    `LPHT_ASSERT(a_no_take_when_full, i_clk, i_rst_n, req_valid && req_ready |=> !req_ready)
endmodule

bind linear_probe_hash_table_top lpht_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data)
);

FILE: test/tb_top.sv
// Testbench of the linear probe hash table: directed and random words checked against a predictor.
`timescale 1ns / 100ps

// Predicts each result word from its own copy of the table and holds them in order.
class hash_table_predictor;
    localparam int SLOTS = lpht_pkg::MAX_SLOTS_DEF;

    bit                       used[SLOTS];
    bit [lpht_pkg::KEY_W-1:0]  keys[SLOTS];
    bit [lpht_pkg::HASH_W-1:0] hashes[SLOTS];
    bit [lpht_pkg::VAL_W-1:0]  vals[SLOTS];
    int unsigned cap_log2;
    int unsigned entries;
    lpht_pkg::t_rsp pending_rsp[$];
    int errors;

    function new();
        cap_log2 = lpht_pkg::RESET_CAP_LOG2;
        clear();
        errors = 0;
    endfunction

    function void clear();
        foreach (used[i]) used[i] = 0;
        entries = 0;
    endfunction

    // Register write: saturate into the legal range, then empty the table.
    function void set_capacity(bit [lpht_pkg::CFG_W-1:0] v);
        int unsigned c;
        c = v;
        if (c < 3) c = 3;
        if (c > 10) c = 10;
        cap_log2 = c;
        clear();
    endfunction

    // Slot of the key or the first hole; -1 if the walk wraps fully.
    function int find(bit [63:0] key, bit [31:0] hash, output bit hit);
        int unsigned mask, idx;
        mask = (1 << cap_log2) - 1;
        idx = hash & mask;
        hit = 0;
        for (int n = 0; n <= mask; n++) begin
            if (!used[idx]) return idx;
            if (keys[idx] == key) begin
                hit = 1;
                return idx;
            end
            idx = (idx + 1) & mask;
        end
        return -1;
    endfunction

    // Double the table, reinserting by stored hash in ascending old-slot order.
    function void grow();
        bit                t_used[SLOTS];
        bit [63:0]         t_keys[SLOTS];
        bit [31:0]         t_hashes[SLOTS];
        bit [63:0]         t_vals[SLOTS];
        int unsigned new_mask, idx;
        new_mask = (2 << cap_log2) - 1;
        foreach (t_used[i]) t_used[i] = 0;
        for (int i = 0; i < (1 << cap_log2); i++) begin
            if (used[i]) begin
                idx = hashes[i] & new_mask;
                for (int n = 0; n <= new_mask; n++) begin
                    if (!t_used[idx] || t_keys[idx] == keys[i]) break;
                    idx = (idx + 1) & new_mask;
                end
                t_used[idx] = 1;
                t_keys[idx] = keys[i];
                t_hashes[idx] = hashes[i];
                t_vals[idx] = vals[i];
            end
        end
        used = t_used;
        keys = t_keys;
        hashes = t_hashes;
        vals = t_vals;
        cap_log2++;
    endfunction

    // Accepted request word: update the table and queue the expected result.
    function void note_request(lpht_pkg::t_req r);
        lpht_pkg::t_rsp e;
        bit hit;
        bit ok;
        int at;
        e = '0;
        e.status = lpht_pkg::STATUS_OK;
        at = find(r.key, r.key_hash, hit);
        if (r.mode == lpht_pkg::MODE_LOOKUP) begin
            if (at >= 0 && hit) begin
                e.found = 1;
                e.result_value = vals[at];
            end
        end else if (at >= 0 && hit) begin
            e.found = 1;
            vals[at] = r.value;
        end else begin
            ok = 1;
            if ((entries + 1) * 4 >= (3 << cap_log2)) begin
                if (cap_log2 < 10) grow();
                else ok = 0;
            end
            if (ok) begin
                at = find(r.key, r.key_hash, hit);
                if (at < 0 || hit) ok = 0;
            end
            if (ok) begin
                used[at] = 1;
                keys[at] = r.key;
                hashes[at] = r.key_hash;
                vals[at] = r.value;
                entries++;
            end else begin
                e.status = lpht_pkg::STATUS_FULL;
            end
        end
        e.entry_total = lpht_pkg::CNT_W'(entries);
        pending_rsp.push_back(e);
    endfunction

    // Accepted result word: compare with the oldest expectation.
    function void check_result(lpht_pkg::t_rsp a);
        lpht_pkg::t_rsp e;
        if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, a);
            errors++;
            return;
        end
        e = pending_rsp.pop_front();
        if (a.found !== e.found) begin
            $display("%0t: found exp %0d got %0d", $time, e.found, a.found);
            errors++;
        end
        if (a.result_value !== e.result_value) begin
            $display("%0t: result_value exp %h got %h", $time, e.result_value,
                     a.result_value);
            errors++;
        end
        if (a.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
            errors++;
        end
        if (a.entry_total !== e.entry_total) begin
            $display("%0t: entry_total exp %0d got %0d", $time, e.entry_total,
                     a.entry_total);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import lpht_pkg::*;

    logic i_clk;
    logic i_rst_n;

    lpht_if #(.T(logic [CFG_W-1:0])) cfg_if ();
    lpht_if #(.T(t_req))             req_if ();
    lpht_if #(.T(t_rsp))             rsp_if ();

    linear_probe_hash_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg_if),
        .req     (req_if),
        .rsp     (rsp_if)
    );

    hash_table_predictor table_model;
    bit idle_on;                // enables random gaps on both sides
    bit [63:0] pool_key[64];
    bit [31:0] pool_hash[64];

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int p;
        if (!idle_on) return 0;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Result side: random stall, check each accepted word.
    initial begin
        int stall;
        rsp_if.ready = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                rsp_if.ready = 1'b0;
            end else begin
                rsp_if.ready = 1'b1;
                stall = gap_len();
            end
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready)
                table_model.check_result(rsp_if.data);
        end
    end

    task automatic send_word(t_req r);
        int g;
        g = gap_len();
        repeat (g) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
        end
        @(negedge i_clk);
        req_if.valid = 1'b1;
        req_if.data = r;
        do @(posedge i_clk); while (!req_if.ready);
        table_model.note_request(r);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (table_model.pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write, only with the table idle.
    task automatic write_capacity(bit [CFG_W-1:0] v);
        drain();
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.data = v;
        do @(posedge i_clk); while (!cfg_if.ready);
        table_model.set_capacity(v);
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic t_req make_word(bit mode, bit [63:0] k, bit [31:0] h, bit [63:0] v);
        t_req r;
        r.mode = mode;
        r.key = k;
        r.key_hash = h;
        r.value = v;
        return r;
    endfunction

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // New key pool; some hashes share low bits to build long chains.
    function automatic void fill_pool();
        bit [31:0] base;
        base = $urandom;
        foreach (pool_key[i]) begin
            pool_key[i] = rand64();
            pool_hash[i] = $urandom;
            if ($urandom_range(9) < 3)
                pool_hash[i][9:0] = base[9:0] + 10'($urandom_range(2));
        end
    endfunction

    // Mostly pool keys with their own hash; the rest stray keys or hashes.
    task automatic random_phase(int n, int pool);
        int j;
        bit [63:0] k;
        bit [31:0] h;
        for (int i = 0; i < n; i++) begin
            j = $urandom_range(pool - 1);
            k = pool_key[j];
            h = pool_hash[j];
            if ($urandom_range(9) == 0) k = rand64();
            if ($urandom_range(19) == 0) h = $urandom;
            send_word(make_word(1'($urandom_range(1)), k, h, rand64()));
            if (i % 60 == 59) idle_on = !idle_on;
        end
    endtask

    initial begin
        bit [63:0] ones;
        ones = '1;
        table_model = new();
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty lookup, extremes, replace, wrap-around chain, growth 8 -> 16.
        send_word(make_word(MODE_LOOKUP, 64'd0, 32'd0, ones));
        send_word(make_word(MODE_PUT, ones, '1, ones));
        send_word(make_word(MODE_LOOKUP, ones, '1, 64'd0));
        send_word(make_word(MODE_PUT, 64'd0, 32'd7, 64'd0));
        send_word(make_word(MODE_PUT, 64'd5, 32'd7, 64'h55));
        send_word(make_word(MODE_LOOKUP, 64'd5, 32'd7, 64'd0));
        send_word(make_word(MODE_PUT, 64'd5, 32'd7, 64'hAAAA_5555_AAAA_5555));
        send_word(make_word(MODE_LOOKUP, 64'd5, 32'd7, 64'd0));
        send_word(make_word(MODE_LOOKUP, 64'd6, 32'd7, 64'd0));
        send_word(make_word(MODE_PUT, 64'd9, 32'd15, 64'h99));
        send_word(make_word(MODE_PUT, 64'd10, 32'd0, 64'h10));
        send_word(make_word(MODE_PUT, 64'd11, 32'hFFFF_FFF6, 64'h11));
        send_word(make_word(MODE_LOOKUP, 64'd9, 32'd15, 64'd0));
        send_word(make_word(MODE_LOOKUP, 64'd0, 32'd7, 64'd0));
        send_word(make_word(MODE_LOOKUP, ones, '1, 64'd0));
        send_word(make_word(MODE_LOOKUP, 64'd11, 32'hFFFF_FFF6, 64'd0));
        send_word(make_word(MODE_PUT, 64'h8000_0000_0000_0000, 32'h8000_0000, 64'd1));
        send_word(make_word(MODE_LOOKUP, 64'd10, 32'd0, 64'd0));

        // Below range saturates to the smallest size.
        write_capacity(4'd0);
        fill_pool();
        random_phase(150, 12);

        // Above range saturates to the largest size.
        write_capacity(4'd15);
        fill_pool();
        random_phase(100, 64);

        write_capacity(4'd4);
        fill_pool();
        random_phase(80, 40);
        drain();
        random_phase(80, 40);

        write_capacity(4'd10);
        fill_pool();
        random_phase(60, 64);

        write_capacity(4'd3);
        fill_pool();
        random_phase(60, 6);

        drain();
        repeat (50) @(posedge i_clk);
        if (table_model.errors == 0 && table_model.pending_rsp.size() == 0)
            $display("[linear_probe_hash_table_top] OK");
        else
            $display("[linear_probe_hash_table_top] ERROR");
        $finish;
    end

    // Run limit
    initial begin
        #20ms;
        $display("[linear_probe_hash_table_top] ERROR");
        $finish;
    end
endmodule
